// ===== design/i2c_master_byte_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Shared property wrappers so the checks compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define I2CMBE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c byte engine check failed");

`define I2CMBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c byte engine check failed");

`else

`define I2CMBE_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define I2CMBE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the front, queue, back and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmbe_pkg;

   localparam int QUEUE_DEPTH   = 4;
   localparam int MSB_POS       = 7;
   localparam int BITS_PER_BYTE = 8;

   localparam int              CSR_ADDR_W     = 3;
   localparam int              CSR_DATA_W     = 32;
   localparam logic            CSR_IDX_TPP    = 1'b0;
   localparam logic [15:0]     TPP_RESET      = 16'd1;

   typedef struct packed {
      logic       mode;
      logic [1:0] command;
      logic [7:0] tx_byte;
      logic       ack_level;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       nack;
      logic       rejected;
   } rsp_payload_type;

   // Raw codes on the request channel.
   localparam logic       MODE_COMMAND = 1'b0;
   localparam logic [1:0] CMD_START    = 2'd0;
   localparam logic [1:0] CMD_WRITE    = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;
   localparam logic [1:0] CMD_STOP     = 2'd3;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_STOP  = 3'd4
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  tx_byte;
      logic        ack_level;
      logic        sda_in;
   } op_item_type;

endpackage

// ===== design/i2c_master_byte_engine_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine
// Command and tick driven I2C master that produces SCL/SDA drive levels.
// ----------------------------------------------------------------------------
// Usage: each request is either a command (start+address, write, read, stop)
// or a timing tick carrying the sampled SDA level. Every request yields exactly
// one response with the SCL/SDA drive levels, busy, done, received byte, nack
// and rejected flags. ticks_per_phase is written through the csr_ port at
// byte address 0 and sets how many ticks each bus half-phase lasts.
// A request accepted into the queue is taken from it by the sequencer, and
// its response is registered in the output register before it shows on rsp_.
// Throughput is one request per cycle unless rsp_stall holds the response.
// Each tick request counts one tick; a half-phase ends once its ticks are counted.
// A four-entry queue lies between the request front end and the sequencer,
// and the response sits in an output register. While rsp_stall is high the
// response holds, the sequencer waits, and requests keep being taken until the
// queue is full, at which point req_stall rises.
// Reset (synchronous) empties the queue, drops rsp_valid, returns the
// sequencer to idle with both lines released and sets ticks_per_phase to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit
   import i2cmbe_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [15:0]  tpp_ff, tpp_in;
   logic         csr_sel_tpp;
   logic         csr_write;
   logic         push;
   op_item_type  push_item;
   logic         queue_full;
   logic         queue_not_empty;
   op_item_type  head_item;
   logic         pop;

   assign csr_pready  = 1'b1;
   assign csr_sel_tpp = (csr_paddr[2] == CSR_IDX_TPP);
   assign csr_write   = csr_psel && csr_penable && csr_pwrite;
   assign tpp_in      = (csr_write && csr_sel_tpp) ? csr_pwdata[15:0] : tpp_ff;
   assign csr_prdata  = csr_sel_tpp ? {{(CSR_DATA_W-16){1'b0}}, tpp_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpp_ff <= TPP_RESET;
      end else begin
         tpp_ff <= tpp_in;
      end
   end

   i2cmbe_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   i2cmbe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   i2cmbe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .ticks_per_phase (tpp_ff),
      .item_valid      (queue_not_empty),
      .item            (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

// ===== design/i2cmbe_front.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine front end
// Accepts requests and classifies them into tick or command operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbe_front
   import i2cmbe_pkg::*;
(
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            push,
   output op_item_type     push_item,
   input  logic            queue_full
);

   op_kind_type kind_w;

   always_comb begin
      if (req_data.mode != MODE_COMMAND) begin
         kind_w = OP_TICK;
      end else begin
         unique case (req_data.command)
            CMD_START: kind_w = OP_START;
            CMD_WRITE: kind_w = OP_WRITE;
            CMD_READ:  kind_w = OP_READ;
            CMD_STOP:  kind_w = OP_STOP;
            default:   kind_w = OP_STOP;
         endcase
      end
   end

   assign req_stall           = queue_full;
   assign push                = req_valid && !queue_full;
   assign push_item.kind      = kind_w;
   assign push_item.tx_byte   = req_data.tx_byte;
   assign push_item.ack_level = req_data.ack_level;
   assign push_item.sda_in    = req_data.sda_in;

endmodule

// ===== design/i2cmbe_queue.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine operation queue
// Small FIFO that decouples request acceptance from bus sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_unit_macros.svh"

module i2cmbe_queue
   import i2cmbe_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  op_item_type push_item,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output op_item_type head_item
);

   // Depth must be a power of two so the pointers wrap on their own.
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = AddrW + 1;

   op_item_type            entry_ff [Depth];
   logic [AddrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AddrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + AddrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `I2CMBE_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(Depth))
   `I2CMBE_ASSERT_NEXT(a_push_counts, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + CntW'(1))

endmodule

// ===== design/i2cmbe_back.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine back end
// Bus phase sequencer with an output register toward the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_unit_macros.svh"

module i2cmbe_back
   import i2cmbe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [15:0]     ticks_per_phase,
   input  logic            item_valid,
   input  op_item_type     item,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_S_REL  = 14'b00000000000010,
      ST_S_FALL = 14'b00000000000100,
      ST_S_LOW  = 14'b00000000001000,
      ST_W_LOW  = 14'b00000000010000,
      ST_W_HIGH = 14'b00000000100000,
      ST_WA_LOW = 14'b00000001000000,
      ST_WA_HI  = 14'b00000010000000,
      ST_R_LOW  = 14'b00000100000000,
      ST_R_HIGH = 14'b00001000000000,
      ST_RA_LOW = 14'b00010000000000,
      ST_RA_HI  = 14'b00100000000000,
      ST_P_A    = 14'b01000000000000,
      ST_P_B    = 14'b10000000000000
   } seq_state_type;

   seq_state_type   state_ff, state_in;
   logic [3:0]      bit_cnt_ff, bit_cnt_in;
   logic [7:0]      shift_ff, shift_in;
   logic            scl_drv_ff, scl_drv_in;
   logic            sda_drv_ff, sda_drv_in;
   logic [15:0]     phase_ff, phase_in;
   logic            ack_send_ff, ack_send_in;
   logic            nack_ff, nack_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic            load_ok;
   logic [15:0]     phase_inc;
   logic [15:0]     phase_len;
   logic            phase_end;
   logic [3:0]      bit_inc;
   logic            done_w;
   logic [7:0]      rx_w;
   logic            rejected_w;

   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign pop       = item_valid && load_ok;
   assign phase_inc = phase_ff + 16'd1;
   assign phase_len = (ticks_per_phase == '0) ? 16'd1 : ticks_per_phase;
   // A wrapped counter also ends the phase.
   assign phase_end = (phase_inc >= phase_len) || (phase_inc == '0);
   assign bit_inc   = bit_cnt_ff + 4'd1;

   always_comb begin
      state_in    = state_ff;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      scl_drv_in  = scl_drv_ff;
      sda_drv_in  = sda_drv_ff;
      phase_in    = phase_ff;
      ack_send_in = ack_send_ff;
      nack_in     = nack_ff;
      done_w      = 1'b0;
      rx_w        = '0;
      rejected_w  = 1'b0;
      if (pop) begin
         if (item.kind != OP_TICK) begin
            if (state_ff != ST_IDLE) begin
               rejected_w = 1'b1;
            end else begin
               nack_in    = 1'b0;
               phase_in   = '0;
               bit_cnt_in = '0;
               unique case (item.kind)
                  OP_START: begin
                     shift_in   = item.tx_byte;
                     scl_drv_in = 1'b1;
                     sda_drv_in = 1'b1;
                     state_in   = ST_S_REL;
                  end
                  OP_WRITE: begin
                     shift_in   = item.tx_byte;
                     scl_drv_in = 1'b0;
                     sda_drv_in = item.tx_byte[MSB_POS];
                     state_in   = ST_W_LOW;
                  end
                  OP_READ: begin
                     shift_in    = '0;
                     ack_send_in = item.ack_level;
                     scl_drv_in  = 1'b0;
                     sda_drv_in  = 1'b1;
                     state_in    = ST_R_LOW;
                  end
                  OP_STOP: begin
                     sda_drv_in = 1'b0;
                     state_in   = ST_P_A;
                  end
                  default: begin
                     state_in = state_ff;
                  end
               endcase
            end
         end else if (state_ff != ST_IDLE) begin
            phase_in = phase_inc;
            if (phase_end) begin
               phase_in = '0;
               unique case (state_ff)
                  ST_S_REL: begin
                     sda_drv_in = 1'b0;
                     state_in   = ST_S_FALL;
                  end
                  ST_S_FALL: begin
                     scl_drv_in = 1'b0;
                     state_in   = ST_S_LOW;
                  end
                  ST_S_LOW: begin
                     sda_drv_in = shift_ff[MSB_POS];
                     state_in   = ST_W_LOW;
                  end
                  ST_W_LOW: begin
                     scl_drv_in = 1'b1;
                     state_in   = ST_W_HIGH;
                  end
                  ST_W_HIGH: begin
                     shift_in   = {shift_ff[MSB_POS-1:0], 1'b0};
                     bit_cnt_in = bit_inc;
                     scl_drv_in = 1'b0;
                     if (bit_inc >= 4'(BITS_PER_BYTE)) begin
                        sda_drv_in = 1'b1;
                        state_in   = ST_WA_LOW;
                     end else begin
                        sda_drv_in = shift_ff[MSB_POS-1];
                        state_in   = ST_W_LOW;
                     end
                  end
                  ST_WA_LOW: begin
                     scl_drv_in = 1'b1;
                     state_in   = ST_WA_HI;
                  end
                  ST_WA_HI: begin
                     scl_drv_in = 1'b0;
                     if (item.sda_in) begin
                        // No acknowledge: finish with a stop of our own.
                        nack_in    = 1'b1;
                        sda_drv_in = 1'b0;
                        state_in   = ST_P_A;
                     end else begin
                        sda_drv_in = 1'b1;
                        state_in   = ST_IDLE;
                        done_w     = 1'b1;
                     end
                  end
                  ST_R_LOW: begin
                     scl_drv_in = 1'b1;
                     state_in   = ST_R_HIGH;
                  end
                  ST_R_HIGH: begin
                     shift_in   = {shift_ff[MSB_POS-1:0], item.sda_in};
                     bit_cnt_in = bit_inc;
                     scl_drv_in = 1'b0;
                     if (bit_inc >= 4'(BITS_PER_BYTE)) begin
                        sda_drv_in = ack_send_ff;
                        state_in   = ST_RA_LOW;
                     end else begin
                        sda_drv_in = 1'b1;
                        state_in   = ST_R_LOW;
                     end
                  end
                  ST_RA_LOW: begin
                     scl_drv_in = 1'b1;
                     state_in   = ST_RA_HI;
                  end
                  ST_RA_HI: begin
                     scl_drv_in = 1'b0;
                     sda_drv_in = 1'b1;
                     state_in   = ST_IDLE;
                     done_w     = 1'b1;
                     rx_w       = shift_ff;
                  end
                  ST_P_A: begin
                     scl_drv_in = 1'b1;
                     state_in   = ST_P_B;
                  end
                  ST_P_B: begin
                     sda_drv_in = 1'b1;
                     state_in   = ST_IDLE;
                     done_w     = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp_in.scl_level = scl_drv_in;
      rsp_in.sda_level = sda_drv_in;
      rsp_in.busy_res  = (state_in != ST_IDLE);
      rsp_in.done_res  = done_w;
      rsp_in.rx_byte   = rx_w;
      rsp_in.nack      = nack_in;
      rsp_in.rejected  = rejected_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         scl_drv_ff   <= 1'b1;
         sda_drv_ff   <= 1'b1;
         phase_ff     <= '0;
         ack_send_ff  <= 1'b0;
         nack_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         shift_ff     <= shift_in;
         scl_drv_ff   <= scl_drv_in;
         sda_drv_ff   <= sda_drv_in;
         phase_ff     <= phase_in;
         ack_send_ff  <= ack_send_in;
         nack_ff      <= nack_in;
         if (load_ok) begin
            rsp_valid_ff <= pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `I2CMBE_ASSERT_IMPLIES(a_done_not_busy, clock, reset, rsp_valid_ff && rsp_ff.done_res, !rsp_ff.busy_res)
   `I2CMBE_ASSERT_IMPLIES(a_idle_phase_clear, clock, reset, state_ff == ST_IDLE, phase_ff == '0)
   `I2CMBE_ASSERT_IMPLIES(a_bit_count_range, clock, reset, 1'b1, bit_cnt_ff <= 4'(BITS_PER_BYTE))
   `I2CMBE_ASSERT_NEXT(a_reject_when_busy, clock, reset, pop && rejected_w, rsp_valid_ff && rsp_ff.busy_res)

endmodule
